@@ hdl/mexp_pkg.sv @@
// Shared widths, types and constants of the modular exponentiation block.
`default_nettype none
package mexp_pkg;
	localparam int MOD_WIDTH = 32;
	localparam int EXP_WIDTH = 63;
	localparam int CNT_WIDTH = $clog2(MOD_WIDTH);

	typedef logic [MOD_WIDTH-1:0] mod_t;
	typedef logic [EXP_WIDTH-1:0] exp_t;
	typedef logic [CNT_WIDTH-1:0] cnt_t;

	localparam mod_t MOD_RESET = MOD_WIDTH'(64'd1000000007);
	localparam mod_t MOD_ONE = MOD_WIDTH'(1);
	localparam cnt_t CNT_LAST = CNT_WIDTH'(MOD_WIDTH - 1);
endpackage
`default_nettype wire

@@ hdl/mexp_if.sv @@
// Valid/ready channel interfaces of the modular exponentiation block.
`default_nettype none
interface mexp_item_if;
	logic valid;
	logic ready;
	mexp_pkg::mod_t base;
	mexp_pkg::exp_t exponent;

	modport source (output valid, output base, output exponent, input ready);
	modport sink (input valid, input base, input exponent, output ready);
endinterface

interface mexp_result_if;
	logic valid;
	logic ready;
	mexp_pkg::mod_t residue;

	modport source (output valid, output residue, input ready);
	modport sink (input valid, input residue, output ready);
endinterface

interface mexp_cfg_if;
	logic valid;
	logic ready;
	mexp_pkg::mod_t modulus;

	modport source (output valid, output modulus, input ready);
	modport sink (input valid, input modulus, output ready);
endinterface
`default_nettype wire

@@ hdl/modular_exponentiation_top.sv @@
// Modular exponentiation top level: square-and-multiply on one shared modular multiplier.
// Usage:
//   item   : sink channel carrying base and exponent; a transfer starts one computation.
//   result : source channel carrying residue = base^exponent mod modulus (1 for exponent 0).
//   cfg    : sink channel writing the modulus; always ready, write only while idle.
//   A modulus of zero stands for 2^32, so products simply wrap.
// Operation:
//   One bit-serial multiply-reduce unit forms every modular product. A computation
//   reduces the base, then for each exponent bit up to the top set bit checks the bit,
//   multiplies if it is set and squares unless it is the top bit, then finishes;
//   the exponent may have up to 63 bits.
//   item.ready is high only while no computation runs, so items are taken one at a time.
// Output:
//   The residue sits in an output register; the next item is taken while it waits.
//   If the receiver stalls and a second result finishes, the unit holds it until the
//   register is taken.
// Reset:
//   arst_n clears all control state and sets the modulus to 1000000007.
`default_nettype none
module modular_exponentiation_top (
	input wire logic clk,
	input wire logic arst_n,
	mexp_item_if.sink item,
	mexp_result_if.source result,
	mexp_cfg_if.sink cfg
);
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_CHECK,
		ST_MULT,
		ST_SQUARE,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic result_valid_q;
	mexp_pkg::mod_t residue_q;
	mexp_pkg::mod_t modulus_q;

	logic [mexp_pkg::MOD_WIDTH:0] m_q;
	logic [mexp_pkg::MOD_WIDTH+1:0] m2_q;
	mexp_pkg::mod_t x_q;
	mexp_pkg::mod_t y_q;
	mexp_pkg::mod_t acc_q;
	mexp_pkg::mod_t b_q;
	mexp_pkg::mod_t res_q;
	mexp_pkg::exp_t e_q;
	mexp_pkg::cnt_t cnt_q;

	logic [mexp_pkg::MOD_WIDTH+1:0] sum;
	logic [mexp_pkg::MOD_WIDTH+1:0] diff;
	mexp_pkg::mod_t acc_next;
	logic last;
	logic out_free;
	logic more_bits;

	assign item.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign result.valid = result_valid_q;
	assign result.residue = residue_q;

	assign last = (cnt_q == '0);
	assign out_free = !result_valid_q || result.ready;
	assign more_bits = (e_q[mexp_pkg::EXP_WIDTH-1:1] != '0);

	// double-and-add step, reduced from below three moduli
	always_comb begin
		sum = {1'b0, acc_q, 1'b0}
			+ {2'b00, (y_q[mexp_pkg::MOD_WIDTH-1] ? x_q : mexp_pkg::mod_t'(0))};
		if (sum >= m2_q) begin
			diff = sum - m2_q;
		end else if (sum >= {1'b0, m_q}) begin
			diff = sum - {1'b0, m_q};
		end else begin
			diff = sum;
		end
		acc_next = diff[mexp_pkg::MOD_WIDTH-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= mexp_pkg::MOD_RESET;
		end else if (cfg.valid) begin
			modulus_q <= cfg.modulus;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_FINISH && out_free) begin
				result_valid_q <= 1'b1;
			end else if (result.ready) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (item.valid) begin
						state_q <= ST_REDUCE;
					end
				end
				ST_REDUCE: begin
					if (last) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (e_q == '0) begin
						state_q <= ST_FINISH;
					end else if (e_q[0]) begin
						state_q <= ST_MULT;
					end else begin
						state_q <= ST_SQUARE;
					end
				end
				ST_MULT: begin
					if (last) begin
						state_q <= more_bits ? ST_SQUARE : ST_CHECK;
					end
				end
				ST_SQUARE: begin
					if (last) begin
						state_q <= ST_CHECK;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (item.valid) begin
					m_q <= {~|modulus_q, modulus_q};
					m2_q <= {~|modulus_q, modulus_q, 1'b0};
					x_q <= mexp_pkg::MOD_ONE;
					y_q <= item.base;
					acc_q <= '0;
					cnt_q <= mexp_pkg::CNT_LAST;
					e_q <= item.exponent;
					res_q <= mexp_pkg::MOD_ONE;
				end
			end
			ST_REDUCE, ST_MULT, ST_SQUARE: begin
				if (last) begin
					acc_q <= '0;
					cnt_q <= mexp_pkg::CNT_LAST;
					if (state_q == ST_MULT) begin
						res_q <= acc_next;
						if (more_bits) begin
							x_q <= b_q;
							y_q <= b_q;
						end else begin
							e_q <= e_q >> 1;
						end
					end else begin
						b_q <= acc_next;
						if (state_q == ST_SQUARE) begin
							e_q <= e_q >> 1;
						end
					end
				end else begin
					acc_q <= acc_next;
					y_q <= y_q << 1;
					cnt_q <= cnt_q - 1'b1;
				end
			end
			ST_CHECK: begin
				x_q <= e_q[0] ? res_q : b_q;
				y_q <= b_q;
				acc_q <= '0;
				cnt_q <= mexp_pkg::CNT_LAST;
			end
			ST_FINISH: begin
				if (out_free) begin
					residue_q <= res_q;
				end
			end
			default: begin
			end
		endcase
	end

	a_acc_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_REDUCE || state_q == ST_MULT || state_q == ST_SQUARE)
		|-> ({1'b0, acc_q} < m_q))
		else $error("accumulator not reduced below modulus");

	a_base_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK) |-> ({1'b0, b_q} < m_q))
		else $error("running base not reduced below modulus");

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready) |=> (state_q == ST_REDUCE && !item.ready))
		else $error("accepted item did not start base reduction");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(state_q == ST_FINISH))
		else $error("result raised outside finish state");
endmodule
`default_nettype wire
